// File: rtl/assert_macros.svh
// ---------------------------------------------------------------------------
// assertion helpers shared by the rtl files
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, off while reset is high
`define ASSERT_IMPLY(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed: same-cycle implication");

// next-cycle implication, off while reset is high
`define ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed: next-cycle implication");

`endif

// File: rtl/ttc_pkg.sv
// ---------------------------------------------------------------------------
// ttc_pkg
// shared widths, constants and the segment table of the thermistor converter
// ---------------------------------------------------------------------------
`default_nettype none

package ttc_pkg;

   // field widths
   localparam int VOLT_W    = 12;
   localparam int TEMP_W    = 14;
   localparam int RES_W     = 25;
   localparam int REF_W     = 14;
   localparam int SLOPE_W   = 11;
   localparam int SPAN_W    = 14;
   localparam int BASE_W    = 6;
   localparam int BRK_W     = 16;
   localparam int SEG_COUNT = 6;
   localparam int SEG_IDX_W = 3;

   // defaults for the top level parameters
   localparam int DEF_FRAC_BITS = 8;
   localparam int DIV_STEPS     = 4;

   // divider constants
   localparam logic [VOLT_W-1:0] SUPPLY_MV = 12'd3296;
   localparam logic [REF_W-1:0]  REF_OHMS  = 14'd10000;

   // outer bounds of the segment chain
   localparam logic [BRK_W-1:0] RANGE_TOP = 16'd33970;
   localparam logic [BRK_W-1:0] RANGE_LOW = 16'd2484;

   typedef logic [SEG_IDX_W-1:0] seg_idx_type;

   // segment codes, 10 degrees each
   localparam seg_idx_type SEG_0_10  = 3'd0;
   localparam seg_idx_type SEG_10_20 = 3'd1;
   localparam seg_idx_type SEG_20_30 = 3'd2;
   localparam seg_idx_type SEG_30_40 = 3'd3;
   localparam seg_idx_type SEG_40_50 = 3'd4;
   localparam seg_idx_type SEG_50_60 = 3'd5;

   typedef struct packed {
      logic [BRK_W-1:0]   top;
      logic [BRK_W-1:0]   lower;
      logic [BASE_W-1:0]  base;
      logic [SLOPE_W-1:0] slope;
   } seg_type;

   // item sideband carried through the temperature divider
   typedef struct packed {
      logic              hit;
      logic [RES_W-1:0]  res;
      logic [BASE_W-1:0] base;
   } post_type;

   // segment table, [lower, top) in ohms, base in C, slope in ohms per C
   function automatic seg_type seg_lookup(seg_idx_type idx);
      seg_type seg;
      case (idx)
         SEG_0_10:  seg = '{top: 16'd33970, lower: 16'd20310, base: 6'd0,  slope: 11'd1366};
         SEG_10_20: seg = '{top: 16'd20310, lower: 16'd12570, base: 6'd10, slope: 11'd774};
         SEG_20_30: seg = '{top: 16'd12570, lower: 16'd8034,  base: 6'd20, slope: 11'd454};
         SEG_30_40: seg = '{top: 16'd8034,  lower: 16'd5298,  base: 6'd30, slope: 11'd274};
         SEG_40_50: seg = '{top: 16'd5298,  lower: 16'd3586,  base: 6'd40, slope: 11'd171};
         SEG_50_60: seg = '{top: 16'd3586,  lower: 16'd2484,  base: 6'd50, slope: 11'd110};
         default:   seg = '{top: 16'd33970, lower: 16'd20310, base: 6'd0,  slope: 11'd1366};
      endcase
      return seg;
   endfunction

endpackage

`default_nettype wire

// File: rtl/ttc_front.sv
// ---------------------------------------------------------------------------
// ttc_front
// voltage to divider operands: v*10000 over (3296 - v), with the supply check
// ---------------------------------------------------------------------------
`default_nettype none

module ttc_front (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          in_valid,
   input  wire logic [ttc_pkg::VOLT_W-1:0]    in_volt,
   output logic                               out_valid,
   output logic [ttc_pkg::RES_W-1:0]          out_num,
   output logic [ttc_pkg::VOLT_W-1:0]         out_den,
   output logic                               out_ok
);

   logic                         valid_ff;
   logic [ttc_pkg::RES_W-1:0]    num_ff, num_in;
   logic [ttc_pkg::VOLT_W-1:0]   den_ff, den_in;
   logic                         ok_ff, ok_in;

   // operands; at or above the supply the divide yields zero by a dummy divisor
   always_comb begin
      ok_in = (in_volt < ttc_pkg::SUPPLY_MV);
      if (ok_in) begin
         num_in = ttc_pkg::RES_W'(in_volt) * ttc_pkg::RES_W'(ttc_pkg::REF_OHMS);
         den_in = ttc_pkg::SUPPLY_MV - in_volt;
      end else begin
         num_in = '0;
         den_in = ttc_pkg::VOLT_W'(1);
      end
   end

   // valid bit
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= in_valid;
      end
   end

   // payload
   always_ff @(posedge clock) begin
      num_ff <= num_in;
      den_ff <= den_in;
      ok_ff  <= ok_in;
   end

   assign out_valid = valid_ff;
   assign out_num   = num_ff;
   assign out_den   = den_ff;
   assign out_ok    = ok_ff;

endmodule

`default_nettype wire

// File: rtl/ttc_div.sv
// ---------------------------------------------------------------------------
// ttc_div
// pipelined restoring divider, a fixed number of quotient bits per stage
// ---------------------------------------------------------------------------
`default_nettype none

`include "assert_macros.svh"

module ttc_div #(
   parameter int NUM_W  = ttc_pkg::RES_W,
   parameter int DEN_W  = ttc_pkg::VOLT_W,
   parameter int STEPS  = ttc_pkg::DIV_STEPS,
   parameter int SIDE_W = 1
) (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              in_valid,
   input  wire logic [NUM_W-1:0]  in_num,
   input  wire logic [DEN_W-1:0]  in_den,
   input  wire logic [SIDE_W-1:0] in_side,
   output logic                   out_valid,
   output logic [NUM_W-1:0]       out_quo,
   output logic [SIDE_W-1:0]      out_side
);

   localparam int NS    = (NUM_W + STEPS - 1) / STEPS;
   localparam int PAD_W = NS * STEPS;

   logic              valid_ff [NS];
   logic [DEN_W-1:0]  rem_ff   [NS];
   logic [DEN_W-1:0]  den_ff   [NS];
   logic [PAD_W-1:0]  num_ff   [NS];
   logic [PAD_W-1:0]  quo_ff   [NS];
   logic [SIDE_W-1:0] side_ff  [NS];

   for (genvar k = 0; k < NS; k++) begin : g_stage
      logic              valid_src;
      logic [DEN_W-1:0]  rem_src;
      logic [DEN_W-1:0]  den_src;
      logic [PAD_W-1:0]  num_src;
      logic [PAD_W-1:0]  quo_src;
      logic [SIDE_W-1:0] side_src;
      logic [DEN_W-1:0]  rem_in;
      logic [PAD_W-1:0]  num_in;
      logic [PAD_W-1:0]  quo_in;

      // stage source: the ports or the stage before
      if (k == 0) begin : g_first
         assign valid_src = in_valid;
         assign rem_src   = '0;
         assign den_src   = in_den;
         assign num_src   = PAD_W'(in_num);
         assign quo_src   = '0;
         assign side_src  = in_side;
      end else begin : g_next
         assign valid_src = valid_ff[k-1];
         assign rem_src   = rem_ff[k-1];
         assign den_src   = den_ff[k-1];
         assign num_src   = num_ff[k-1];
         assign quo_src   = quo_ff[k-1];
         assign side_src  = side_ff[k-1];
      end

      // shift-subtract steps of this stage, msb first
      always_comb begin
         logic [DEN_W:0] trial;
         rem_in = rem_src;
         num_in = num_src;
         quo_in = quo_src;
         trial  = '0;
         for (int s = 0; s < STEPS; s++) begin
            trial  = {rem_in, num_in[PAD_W-1]};
            num_in = num_in << 1;
            if (trial >= {1'b0, den_src}) begin
               rem_in = DEN_W'(trial - {1'b0, den_src});
               quo_in = {quo_in[PAD_W-2:0], 1'b1};
            end else begin
               rem_in = trial[DEN_W-1:0];
               quo_in = {quo_in[PAD_W-2:0], 1'b0};
            end
         end
      end

      // valid bit
      always_ff @(posedge clock) begin
         if (reset) begin
            valid_ff[k] <= 1'b0;
         end else begin
            valid_ff[k] <= valid_src;
         end
      end

      // payload
      always_ff @(posedge clock) begin
         rem_ff[k]  <= rem_in;
         den_ff[k]  <= den_src;
         num_ff[k]  <= num_in;
         quo_ff[k]  <= quo_in;
         side_ff[k] <= side_src;
      end
   end

   assign out_valid = valid_ff[NS-1];
   assign out_quo   = quo_ff[NS-1][NUM_W-1:0];
   assign out_side  = side_ff[NS-1];

   // a finished item always leaves a proper remainder
   `ASSERT_IMPLY(a_rem_below_den, clock, reset, valid_ff[NS-1], rem_ff[NS-1] < den_ff[NS-1])

endmodule

`default_nettype wire

// File: rtl/ttc_seg.sv
// ---------------------------------------------------------------------------
// ttc_seg
// segment search on the resistance and setup of the temperature divide
// ---------------------------------------------------------------------------
`default_nettype none

module ttc_seg #(
   parameter int FRAC_BITS = ttc_pkg::DEF_FRAC_BITS
) (
   input  wire logic                                clock,
   input  wire logic                                reset,
   input  wire logic                                in_valid,
   input  wire logic [ttc_pkg::RES_W-1:0]           in_res,
   input  wire logic                                in_ok,
   output logic                                     out_valid,
   output logic [ttc_pkg::SPAN_W+FRAC_BITS-1:0]     out_num,
   output logic [ttc_pkg::SLOPE_W-1:0]              out_slope,
   output ttc_pkg::post_type                        out_side
);

   localparam int NUM_W = ttc_pkg::SPAN_W + FRAC_BITS;

   logic                          valid_ff;
   logic [NUM_W-1:0]              num_ff, num_in;
   logic [ttc_pkg::SLOPE_W-1:0]   slope_ff, slope_in;
   ttc_pkg::post_type             side_ff, side_in;
   logic [ttc_pkg::SEG_COUNT-1:0] hit_vec;

   // one compare pair per segment, lower bound inclusive
   always_comb begin
      ttc_pkg::seg_type seg;
      for (int i = 0; i < ttc_pkg::SEG_COUNT; i++) begin
         seg = ttc_pkg::seg_lookup(ttc_pkg::seg_idx_type'(i));
         hit_vec[i] = in_ok
                    && (in_res <  ttc_pkg::RES_W'(seg.top))
                    && (in_res >= ttc_pkg::RES_W'(seg.lower));
      end
   end

   // pick the segment and form span << FRAC_BITS
   always_comb begin
      ttc_pkg::seg_idx_type     sel;
      ttc_pkg::seg_type         cur;
      logic                     hit;
      logic [ttc_pkg::RES_W-1:0] diff;
      logic [ttc_pkg::SPAN_W-1:0] span;
      sel = ttc_pkg::SEG_0_10;
      hit = 1'b0;
      for (int i = ttc_pkg::SEG_COUNT - 1; i >= 0; i--) begin
         if (hit_vec[i]) begin
            sel = ttc_pkg::seg_idx_type'(i);
            hit = 1'b1;
         end
      end
      cur  = ttc_pkg::seg_lookup(sel);
      diff = ttc_pkg::RES_W'(cur.top) - in_res;
      span = hit ? diff[ttc_pkg::SPAN_W-1:0] : '0;
      num_in        = NUM_W'(span) << FRAC_BITS;
      slope_in      = cur.slope;
      side_in.hit   = hit;
      side_in.res   = in_res;
      side_in.base  = cur.base;
   end

   // valid bit
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= in_valid;
      end
   end

   // payload
   always_ff @(posedge clock) begin
      num_ff   <= num_in;
      slope_ff <= slope_in;
      side_ff  <= side_in;
   end

   assign out_valid = valid_ff;
   assign out_num   = num_ff;
   assign out_slope = slope_ff;
   assign out_side  = side_ff;

endmodule

`default_nettype wire

// File: rtl/thermistor_temperature_convert.sv
// ---------------------------------------------------------------------------
// thermistor_temperature_convert
// ntc divider voltage to resistance and piecewise linear temperature
// ---------------------------------------------------------------------------
//  channel   ports                                    handshake
//  request   req_voltage_mv                           start high, busy low
//  response  rsp_temperature_q8, rsp_resistance_ohms, rsp_valid strobe,
//            rsp_in_range                             one cycle
//
//  one item per clock; busy stays low
//  each item passes the front register, the resistance divider pipeline,
//  the segment register, the temperature divider and the response register
//  synchronous reset clears every valid bit; nothing else is reset
//  results are not held back: each shows for one cycle on rsp_valid
// ---------------------------------------------------------------------------
`default_nettype none

`include "assert_macros.svh"

module thermistor_temperature_convert #(
   parameter int FRAC_BITS = ttc_pkg::DEF_FRAC_BITS,
   parameter int DIV_STEPS = ttc_pkg::DIV_STEPS
) (
   input  wire logic                         clock,
   input  wire logic                         reset,
   input  wire logic                         start,
   output logic                              busy,
   input  wire logic [ttc_pkg::VOLT_W-1:0]   req_voltage_mv,
   output logic                              rsp_valid,
   output logic [ttc_pkg::TEMP_W-1:0]        rsp_temperature_q8,
   output logic [ttc_pkg::RES_W-1:0]         rsp_resistance_ohms,
   output logic                              rsp_in_range
);

   localparam int NUM2_W  = ttc_pkg::SPAN_W + FRAC_BITS;
   localparam int SUM_W   = NUM2_W + 1;
   localparam int NS1     = (ttc_pkg::RES_W + DIV_STEPS - 1) / DIV_STEPS;
   localparam int NS2     = (NUM2_W + DIV_STEPS - 1) / DIV_STEPS;
   localparam int LAT     = 3 + NS1 + NS2;
   localparam int POST_W  = $bits(ttc_pkg::post_type);

   logic                          accept;
   logic                          fr_valid;
   logic [ttc_pkg::RES_W-1:0]     fr_num;
   logic [ttc_pkg::VOLT_W-1:0]    fr_den;
   logic                          fr_ok;
   logic                          d1_valid;
   logic [ttc_pkg::RES_W-1:0]     d1_res;
   logic                          d1_ok;
   logic                          sg_valid;
   logic [NUM2_W-1:0]             sg_num;
   logic [ttc_pkg::SLOPE_W-1:0]   sg_slope;
   ttc_pkg::post_type             sg_side;
   logic                          d2_valid;
   logic [NUM2_W-1:0]             d2_quo;
   logic [POST_W-1:0]             d2_side_bits;
   ttc_pkg::post_type             d2_side;

   logic                          rsp_valid_ff;
   logic [ttc_pkg::TEMP_W-1:0]    temp_ff, temp_in;
   logic [ttc_pkg::RES_W-1:0]     res_ff;
   logic                          range_ff;
   logic                          res_in_chain;

   // never stalls
   assign busy   = 1'b0;
   assign accept = start && !busy;

   // operand setup
   ttc_front u_front (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (accept),
      .in_volt   (req_voltage_mv),
      .out_valid (fr_valid),
      .out_num   (fr_num),
      .out_den   (fr_den),
      .out_ok    (fr_ok)
   );

   // resistance divide
   ttc_div #(
      .NUM_W  (ttc_pkg::RES_W),
      .DEN_W  (ttc_pkg::VOLT_W),
      .STEPS  (DIV_STEPS),
      .SIDE_W (1)
   ) u_div_res (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (fr_valid),
      .in_num    (fr_num),
      .in_den    (fr_den),
      .in_side   (fr_ok),
      .out_valid (d1_valid),
      .out_quo   (d1_res),
      .out_side  (d1_ok)
   );

   // segment search
   ttc_seg #(
      .FRAC_BITS (FRAC_BITS)
   ) u_seg (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (d1_valid),
      .in_res    (d1_res),
      .in_ok     (d1_ok),
      .out_valid (sg_valid),
      .out_num   (sg_num),
      .out_slope (sg_slope),
      .out_side  (sg_side)
   );

   // temperature divide by the segment slope
   ttc_div #(
      .NUM_W  (NUM2_W),
      .DEN_W  (ttc_pkg::SLOPE_W),
      .STEPS  (DIV_STEPS),
      .SIDE_W (POST_W)
   ) u_div_temp (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (sg_valid),
      .in_num    (sg_num),
      .in_den    (sg_slope),
      .in_side   (POST_W'(sg_side)),
      .out_valid (d2_valid),
      .out_quo   (d2_quo),
      .out_side  (d2_side_bits)
   );

   assign d2_side = ttc_pkg::post_type'(d2_side_bits);

   // add the segment base and trim to the output field
   always_comb begin
      logic [SUM_W-1:0] sum;
      sum     = SUM_W'(d2_quo) + (SUM_W'(d2_side.base) << FRAC_BITS);
      temp_in = d2_side.hit ? sum[ttc_pkg::TEMP_W-1:0] : '0;
   end

   // response strobe
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= d2_valid;
      end
   end

   // response payload
   always_ff @(posedge clock) begin
      temp_ff  <= temp_in;
      res_ff   <= d2_side.res;
      range_ff <= d2_side.hit;
   end

   assign rsp_valid           = rsp_valid_ff;
   assign rsp_temperature_q8  = temp_ff;
   assign rsp_resistance_ohms = res_ff;
   assign rsp_in_range        = range_ff;

   // reported resistance lies inside the segment chain
   assign res_in_chain = (rsp_resistance_ohms >= ttc_pkg::RES_W'(ttc_pkg::RANGE_LOW))
                      && (rsp_resistance_ohms < ttc_pkg::RES_W'(ttc_pkg::RANGE_TOP));

   // every accepted item enters the pipeline
   `ASSERT_NEXT(a_front_take, clock, reset, accept, fr_valid)
   // a result only for an item accepted the full pipeline latency before
   `ASSERT_IMPLY(a_rsp_latency, clock, reset, rsp_valid, $past(accept, LAT))
   // out of range reads as zero degrees
   `ASSERT_IMPLY(a_zero_out_range, clock, reset, rsp_valid && !rsp_in_range, rsp_temperature_q8 == '0)
   // in range means resistance inside the segment chain
   `ASSERT_IMPLY(a_range_bounds, clock, reset, rsp_valid && rsp_in_range, res_in_chain)

endmodule

`default_nettype wire

// File: tb/thermistor_temperature_convert_tb.sv
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// thermistor_temperature_convert_tb
// drives divider voltages into the converter with random gaps, predicts
// resistance, segment and fixed point temperature for every accepted item
// and checks each strobed result in order against the prediction
// ---------------------------------------------------------------------------

module thermistor_temperature_convert_tb;

   localparam int FRAC = ttc_pkg::DEF_FRAC_BITS;
   localparam int SEGS = 6;
   localparam int DRAIN_CYCLES = 40;
   localparam int RANDOM_ITEMS = 1650;

   localparam int unsigned SUPPLY = 3296;
   localparam int unsigned REF_R  = 10000;

   // segment breakpoints, base and slope, coldest first
   localparam int unsigned SEG_TOP [SEGS] = '{33970, 20310, 12570, 8034, 5298, 3586};
   localparam int unsigned SEG_LOW [SEGS] = '{20310, 12570, 8034, 5298, 3586, 2484};
   localparam int unsigned SEG_BASE[SEGS] = '{0, 10, 20, 30, 40, 50};
   localparam int unsigned SEG_SLOPE[SEGS] = '{1366, 774, 454, 274, 171, 110};

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic start = 1'b0;
   logic [ttc_pkg::VOLT_W-1:0] req_voltage_mv = '0;
   logic busy;
   logic rsp_valid;
   logic [ttc_pkg::TEMP_W-1:0] rsp_temperature_q8;
   logic [ttc_pkg::RES_W-1:0] rsp_resistance_ohms;
   logic rsp_in_range;

   thermistor_temperature_convert uut (
      .clock               (clock),
      .reset               (reset),
      .start               (start),
      .busy                (busy),
      .req_voltage_mv      (req_voltage_mv),
      .rsp_valid           (rsp_valid),
      .rsp_temperature_q8  (rsp_temperature_q8),
      .rsp_resistance_ohms (rsp_resistance_ohms),
      .rsp_in_range        (rsp_in_range)
   );

   always #5 clock = ~clock;

   // divider resistance in whole ohms, 0 at or above the supply
   function automatic int unsigned divider_ohms(logic [ttc_pkg::VOLT_W-1:0] v);
      int unsigned vv;
      vv = 32'(v);
      if (vv >= SUPPLY) return 0;
      return (vv * REF_R) / (SUPPLY - vv);
   endfunction

   // ordered store of predicted readings and the in-order check
   class reading_ledger;
      typedef struct {
         logic [ttc_pkg::TEMP_W-1:0] temp;
         logic [ttc_pkg::RES_W-1:0]  ohms;
         logic                       hit;
      } reading_type;

      reading_type pending_readings[$];
      int errors = 0;

      function reading_type expected_reading(logic [ttc_pkg::VOLT_W-1:0] v);
         reading_type e;
         int unsigned r;
         longint unsigned t;
         e.temp = '0;
         e.ohms = '0;
         e.hit  = 1'b0;
         r = divider_ohms(v);
         e.ohms = r[ttc_pkg::RES_W-1:0];
         // lower breakpoint inclusive, top exclusive
         for (int i = 0; i < SEGS; i++) begin
            if (!e.hit && r < SEG_TOP[i] && r >= SEG_LOW[i]) begin
               t = ((longint'(SEG_TOP[i] - r)) << FRAC) / SEG_SLOPE[i]
                   + (longint'(SEG_BASE[i]) << FRAC);
               e.temp = t[ttc_pkg::TEMP_W-1:0];
               e.hit  = 1'b1;
            end
         end
         return e;
      endfunction

      function void note_voltage(logic [ttc_pkg::VOLT_W-1:0] v);
         pending_readings.push_back(expected_reading(v));
      endfunction

      function int pending();
         return pending_readings.size();
      endfunction

      function void check_reading(logic [ttc_pkg::TEMP_W-1:0] temp,
                                  logic [ttc_pkg::RES_W-1:0] ohms, logic hit);
         reading_type e;
         if (pending_readings.size() == 0) begin
            errors++;
            $display("%0t: unexpected result temp=%0d ohms=%0d in_range=%0b",
                     $time, temp, ohms, hit);
            return;
         end
         e = pending_readings.pop_front();
         if (temp !== e.temp) begin
            errors++;
            $display("%0t: temperature_q8 expected %0d actual %0d", $time, e.temp, temp);
         end
         if (ohms !== e.ohms) begin
            errors++;
            $display("%0t: resistance_ohms expected %0d actual %0d", $time, e.ohms, ohms);
         end
         if (hit !== e.hit) begin
            errors++;
            $display("%0t: in_range expected %0b actual %0b", $time, e.hit, hit);
         end
      endfunction
   endclass

   reading_ledger ledger = new;

   // one item: random gap, then hold start until accepted
   task automatic send_voltage(input logic [ttc_pkg::VOLT_W-1:0] v);
      int gap;
      gap = $urandom_range(0, 6);
      if (gap > 0) begin
         start <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      start <= 1'b1;
      req_voltage_mv <= v;
      do @(posedge clock); while (busy !== 1'b0);
      ledger.note_voltage(v);
   endtask

   // results are strobed for one cycle, sample at every edge
   always @(posedge clock) begin
      if (!reset && rsp_valid === 1'b1)
         ledger.check_reading(rsp_temperature_q8, rsp_resistance_ohms, rsp_in_range);
   end

   // main sequence
   initial begin
      logic [ttc_pkg::VOLT_W-1:0] directed[$];
      int unsigned bp[7];
      int unsigned v;
      int unsigned pick;

      bp = '{33970, 20310, 12570, 8034, 5298, 3586, 2484};

      repeat (9) @(posedge clock);
      reset <= 1'b0;

      // field extremes, supply edge, alternating bit patterns
      directed = '{12'd0, 12'd1, 12'd3295, 12'd3296, 12'd3297, 12'd3300, 12'd4095,
                   12'd2048, 12'd2730, 12'd1365};
      // straddle every breakpoint: last voltage below it and first at or above
      foreach (bp[i]) begin
         v = 0;
         while (v < SUPPLY && divider_ohms(ttc_pkg::VOLT_W'(v)) < bp[i]) v++;
         directed.push_back(ttc_pkg::VOLT_W'(v - 1));
         directed.push_back(ttc_pkg::VOLT_W'(v));
      end
      foreach (directed[i]) send_voltage(directed[i]);

      // random part, weighted toward the segment range
      for (int n = 0; n < RANDOM_ITEMS; n++) begin
         pick = $urandom_range(0, 99);
         if (pick < 75)
            send_voltage(ttc_pkg::VOLT_W'($urandom_range(640, 2560)));
         else if (pick < 90)
            send_voltage(ttc_pkg::VOLT_W'($urandom_range(0, 3300)));
         else if (pick < 95)
            send_voltage(ttc_pkg::VOLT_W'($urandom_range(3280, 3300)));
         else
            send_voltage(ttc_pkg::VOLT_W'($urandom));
      end
      start <= 1'b0;

      // drain, then keep watching to catch stray strobes
      while (ledger.pending() > 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      if (ledger.errors == 0 && ledger.pending() == 0) begin
         $display("[ OK ] regression clean");
      end else begin
         $display("[FAIL] regression broken");
      end
      $finish;
   end

   // watchdog
   initial begin
      #2000000;
      $display("[FAIL] regression broken");
      $finish;
   end

endmodule
